@@ rtl/core/llg_heun_spin_integrator_assert.svh @@
// assertion macros used by the integrator top level
// each macro expands to one labeled concurrent assertion
`ifndef LLG_HEUN_SPIN_INTEGRATOR_ASSERT_SVH
`define LLG_HEUN_SPIN_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define LLGH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llgh assertion failed");

// next-cycle implication
`define LLGH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llgh assertion failed");

`endif

@@ rtl/core/llgh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgh_pkg
// shared types, register codes and saturation helper for the llg integrator
// ----------------------------------------------------------------------------
package llgh_pkg;

    typedef logic signed [31:0] word_t;

    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_PREC_GAIN = 3'd0;
    localparam logic [CFG_IW-1:0] REG_DAMP_GAIN = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TIME_STEP = 3'd2;
    localparam logic [CFG_IW-1:0] REG_PIN_X     = 3'd3;
    localparam logic [CFG_IW-1:0] REG_PIN_Y     = 3'd4;
    localparam logic [CFG_IW-1:0] REG_PIN_Z     = 3'd5;

    localparam logic PHASE_PREDICT = 1'b0;
    localparam logic PHASE_CORRECT = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;

    localparam word_t WORD_MAX = 32'sh7fffffff;
    localparam word_t WORD_MIN = 32'sh80000000;

    typedef struct packed {
        logic        func;
        logic [9:0]  atom_index;
        word_t       spin_x;
        word_t       spin_y;
        word_t       spin_z;
        word_t       field_x;
        word_t       field_y;
        word_t       field_z;
    } item_t;

    typedef struct packed {
        logic [9:0]  atom_out;
        logic        phase_out;
        word_t       new_spin_x;
        word_t       new_spin_y;
        word_t       new_spin_z;
        logic        zero_length;
    } result_t;

    typedef struct packed {
        logic [15:0] prec_gain;
        logic [15:0] damp_gain;
        logic [31:0] time_step;
        word_t       pin_x;
        word_t       pin_y;
        word_t       pin_z;
    } cfg_t;

    typedef struct packed {
        logic        phase;
        logic [9:0]  atom;
        logic        ok;
    } tag_t;

    typedef struct packed {
        tag_t        tag;
        word_t [2:0] s;
        word_t [2:0] h;
    } work_t;

    typedef struct packed {
        tag_t        tag;
        word_t [2:0] s;
        word_t [2:0] ds;
    } slope_t;

    typedef struct packed {
        tag_t              tag;
        logic [2:0][39:0]  v;
    } vec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic int nxt(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    function automatic word_t sat_w(input logic signed [71:0] x);
        word_t r;
        if (x > 72'sd2147483647)
            r = WORD_MAX;
        else if (x < -72'sd2147483648)
            r = WORD_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

@@ rtl/core/llgh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgh_front
// accepts items, checks the atom range and adds pinning in the corrector
// ----------------------------------------------------------------------------
module llgh_front #(
    parameter int ATOMS = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  llgh_pkg::item_t item,
    input  llgh_pkg::cfg_t  cfg,
    input  logic            q_full,
    output logic            push,
    output llgh_pkg::work_t work
);

    logic            f_valid_reg;
    llgh_pkg::work_t f_work_reg;
    llgh_pkg::work_t w_next;
    logic            accept;

    assign item_stall = f_valid_reg && q_full;
    assign push       = f_valid_reg && !q_full;
    assign accept     = item_valid && !item_stall;
    assign work       = f_work_reg;

    always_comb
    begin
        w_next.tag.phase = item.func;
        w_next.tag.atom  = item.atom_index;
        w_next.tag.ok    = 32'(item.atom_index) < 32'(ATOMS);
        w_next.s[0]      = item.spin_x;
        w_next.s[1]      = item.spin_y;
        w_next.s[2]      = item.spin_z;
        if (item.func == llgh_pkg::PHASE_CORRECT)
        begin
            w_next.h[0] = llgh_pkg::sat_w(72'(item.field_x) + 72'(cfg.pin_x));
            w_next.h[1] = llgh_pkg::sat_w(72'(item.field_y) + 72'(cfg.pin_y));
            w_next.h[2] = llgh_pkg::sat_w(72'(item.field_z) + 72'(cfg.pin_z));
        end
        else
        begin
            w_next.h[0] = item.field_x;
            w_next.h[1] = item.field_y;
            w_next.h[2] = item.field_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (accept)
            f_valid_reg <= 1'b1;
        else if (push)
            f_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            f_work_reg <= w_next;
    end

endmodule

@@ rtl/core/llgh_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgh_queue
// short fifo between the front and the arithmetic pipeline
// ----------------------------------------------------------------------------
module llgh_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  llgh_pkg::work_t     wr_data,
    input  logic                pop,
    output llgh_pkg::work_t     rd_data,
    output llgh_pkg::q_status_t status
);

    llgh_pkg::work_t               slot_reg [0:llgh_pkg::QDEPTH-1];
    logic [llgh_pkg::QAW-1:0]      wr_ptr_reg;
    logic [llgh_pkg::QAW-1:0]      rd_ptr_reg;
    logic [llgh_pkg::QAW:0]        count_reg;

    assign status.full  = count_reg == (llgh_pkg::QAW + 1)'(llgh_pkg::QDEPTH);
    assign status.empty = count_reg == '0;
    assign rd_data      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

@@ rtl/core/llgh_slope.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgh_slope
// six-stage pipeline for ds = g1 (s x h) + g2 (s x (s x h))
// ----------------------------------------------------------------------------
module llgh_slope (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_v,
    input  llgh_pkg::work_t  w,
    input  llgh_pkg::cfg_t   cfg,
    output logic             out_v,
    output llgh_pkg::slope_t out
);

    logic [6:1] v_reg;
    llgh_pkg::tag_t       tag_reg [1:6];
    llgh_pkg::word_t [2:0] s_reg  [1:6];

    logic signed [63:0] pa1_reg [3];
    logic signed [63:0] pb1_reg [3];
    llgh_pkg::word_t [2:0] c2_reg;
    llgh_pkg::word_t [2:0] c3_reg;
    logic signed [63:0] pa3_reg [3];
    logic signed [63:0] pb3_reg [3];
    llgh_pkg::word_t [2:0] c4_reg;
    llgh_pkg::word_t [2:0] d4_reg;
    logic signed [48:0] g1c5_reg [3];
    logic signed [48:0] g2d5_reg [3];
    llgh_pkg::word_t [2:0] ds6_reg;

    llgh_pkg::word_t [2:0] c_next;
    llgh_pkg::word_t [2:0] d_next;
    llgh_pkg::word_t [2:0] ds_next;
    logic signed [64:0] diff_c [3];
    logic signed [64:0] diff_d [3];
    logic signed [49:0] tot    [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_c[i]  = 65'(pa1_reg[i]) - 65'(pb1_reg[i]);
            c_next[i]  = llgh_pkg::sat_w(72'(diff_c[i] >>> 30));
            diff_d[i]  = 65'(pa3_reg[i]) - 65'(pb3_reg[i]);
            d_next[i]  = llgh_pkg::sat_w(72'(diff_d[i] >>> 30));
            tot[i]     = 50'(g1c5_reg[i]) + 50'(g2d5_reg[i]);
            ds_next[i] = llgh_pkg::sat_w(72'(tot[i] >>> 16));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[5:1], in_v};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[1] <= w.tag;
            s_reg[1]   <= w.s;
            for (int k = 2; k <= 6; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
                s_reg[k]   <= s_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                // cross product terms, one multiplier each
                pa1_reg[i] <= $signed(w.s[llgh_pkg::nxt(i)])
                              * $signed(w.h[llgh_pkg::nxt(llgh_pkg::nxt(i))]);
                pb1_reg[i] <= $signed(w.s[llgh_pkg::nxt(llgh_pkg::nxt(i))])
                              * $signed(w.h[llgh_pkg::nxt(i)]);
                pa3_reg[i] <= $signed(s_reg[2][llgh_pkg::nxt(i)])
                              * $signed(c2_reg[llgh_pkg::nxt(llgh_pkg::nxt(i))]);
                pb3_reg[i] <= $signed(s_reg[2][llgh_pkg::nxt(llgh_pkg::nxt(i))])
                              * $signed(c2_reg[llgh_pkg::nxt(i)]);
                g1c5_reg[i] <= $signed({1'b0, cfg.prec_gain}) * $signed(c4_reg[i]);
                g2d5_reg[i] <= $signed({1'b0, cfg.damp_gain}) * $signed(d4_reg[i]);
            end
            c2_reg  <= c_next;
            c3_reg  <= c2_reg;
            c4_reg  <= c3_reg;
            d4_reg  <= d_next;
            ds6_reg <= ds_next;
        end
    end

    assign out_v   = v_reg[6];
    assign out.tag = tag_reg[6];
    assign out.s   = s_reg[6];
    assign out.ds  = ds6_reg;

endmodule

@@ rtl/core/llgh_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgh_update
// per-atom start store and euler or heun step before normalization
// ----------------------------------------------------------------------------
module llgh_update #(
    parameter int ATOMS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_v,
    input  llgh_pkg::slope_t in,
    input  llgh_pkg::cfg_t   cfg,
    output logic             out_v,
    output llgh_pkg::vec_t   out
);

    localparam int AW = (ATOMS > 1) ? $clog2(ATOMS) : 1;

    typedef struct packed {
        llgh_pkg::word_t [2:0] st;
        llgh_pkg::word_t [2:0] ps;
    } entry_t;

    entry_t store [0:ATOMS-1];

    logic [AW-1:0] addr;
    logic [4:1]    v_reg;

    llgh_pkg::tag_t        tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    llgh_pkg::word_t [2:0] s1_reg, ds1_reg;
    entry_t                rd1_reg;
    logic signed [32:0]    a2_reg    [3];
    llgh_pkg::word_t [2:0] base2_reg, base3_reg;
    logic signed [65:0]    prod3_reg [3];
    logic [2:0][39:0]      v4_reg;

    logic signed [32:0]    a_next    [3];
    llgh_pkg::word_t [2:0] base_next;
    llgh_pkg::word_t [2:0] st, ps;
    logic signed [65:0]    step      [3];

    assign addr = AW'(in.tag.atom);

    always_comb
    begin
        st = tag1_reg.ok ? rd1_reg.st : '0;
        ps = tag1_reg.ok ? rd1_reg.ps : '0;
        for (int i = 0; i < 3; i++)
        begin
            if (tag1_reg.phase == llgh_pkg::PHASE_CORRECT)
            begin
                a_next[i]    = 33'($signed(ps[i])) + 33'($signed(ds1_reg[i]));
                base_next[i] = st[i];
            end
            else
            begin
                a_next[i]    = 33'($signed(ds1_reg[i]));
                base_next[i] = s1_reg[i];
            end
            // corrector uses half the step
            step[i] = (tag3_reg.phase == llgh_pkg::PHASE_CORRECT)
                      ? (prod3_reg[i] >>> 27) : (prod3_reg[i] >>> 26);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[3:1], in_v};
    end

    // store access: predictor writes, corrector reads, both at one stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (in_v && in.tag.ok && in.tag.phase == llgh_pkg::PHASE_PREDICT)
                store[addr] <= {in.s, in.ds};
            rd1_reg <= store[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag1_reg  <= in.tag;
            s1_reg    <= in.s;
            ds1_reg   <= in.ds;
            tag2_reg  <= tag1_reg;
            base2_reg <= base_next;
            tag3_reg  <= tag2_reg;
            base3_reg <= base2_reg;
            tag4_reg  <= tag3_reg;
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i]    <= a_next[i];
                prod3_reg[i] <= $signed(a2_reg[i]) * $signed({1'b0, cfg.time_step});
                v4_reg[i]    <= 40'($signed(base3_reg[i])) + 40'(step[i]);
            end
        end
    end

    assign out_v   = v_reg[4];
    assign out.tag = tag4_reg;
    assign out.v   = v4_reg;

endmodule

@@ rtl/core/llgh_norm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgh_norm
// vector normalization: range shift, squares, pipelined root and divides
// ----------------------------------------------------------------------------
module llgh_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_v,
    input  llgh_pkg::vec_t    in,
    output logic              out_v,
    output llgh_pkg::result_t out
);

    localparam int SQ = llgh_pkg::SQ_STEPS;
    localparam int DV = llgh_pkg::DIV_STEPS;

    typedef struct packed {
        llgh_pkg::tag_t   tag;
        logic [2:0]       neg;
        logic             zero;
    } np_t;

    // front stages
    logic [5:1]        v_reg;
    np_t               p_reg [1:4];
    logic [2:0][39:0]  mag1_reg, mag2_reg;
    logic [5:0]        sh2_reg;
    logic              right2_reg;
    logic [2:0][30:0]  mag3_reg;
    logic [2:0][61:0]  sq4_reg;
    logic [2:0][30:0]  mag4_reg;

    // root stages, index 0 loaded by the sum stage
    logic              sq_v_reg    [0:SQ];
    np_t               sq_p_reg    [0:SQ];
    logic [2:0][30:0]  sq_mag_reg  [0:SQ];
    logic [63:0]       sq_n_reg    [0:SQ];
    logic [33:0]       sq_rem_reg  [0:SQ];
    logic [31:0]       sq_root_reg [0:SQ];

    // divide stages, index 0 loaded from the root result
    logic              d_v_reg    [0:DV];
    np_t               d_p_reg    [0:DV];
    logic [31:0]       d_len_reg  [0:DV];
    logic [2:0][31:0]  d_rem_reg  [0:DV];
    logic [2:0][31:0]  d_low_reg  [0:DV];
    logic [2:0][31:0]  d_q_reg    [0:DV];

    logic              o_v_reg;
    llgh_pkg::result_t o_reg;

    // combinational next values
    logic [2:0]        neg_n;
    logic [2:0][39:0]  mag_n;
    logic [39:0]       m_or;
    logic [5:0]        msb;
    logic [2:0][30:0]  shifted;
    logic [35:0]       r_t     [0:SQ-1];
    logic [35:0]       trial   [0:SQ-1];
    logic [33:0]       rem_n   [0:SQ-1];
    logic [31:0]       root_n  [0:SQ-1];
    logic [2:0][61:0]  num;
    logic [2:0][32:0]  d_t     [0:DV-1];
    logic [2:0][31:0]  d_rem_n [0:DV-1];
    logic [2:0][31:0]  d_q_n   [0:DV-1];
    logic [2:0][31:0]  q_sat;
    llgh_pkg::word_t [2:0] o_val;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg_n[i] = in.v[i][39];
            mag_n[i] = in.v[i][39] ? (~in.v[i] + 40'd1) : in.v[i];
        end
        m_or = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
        msb  = '0;
        for (int b = 0; b < 40; b++)
        begin
            if (m_or[b])
                msb = 6'(b);
        end
        for (int i = 0; i < 3; i++)
            shifted[i] = right2_reg ? 31'(mag2_reg[i] >> sh2_reg)
                                    : 31'(mag2_reg[i] << sh2_reg);

        for (int k = 0; k < SQ; k++)
        begin
            r_t[k]   = {sq_rem_reg[k], sq_n_reg[k][63:62]};
            trial[k] = {2'b00, sq_root_reg[k], 2'b01};
            if (r_t[k] >= trial[k])
            begin
                rem_n[k]  = 34'(r_t[k] - trial[k]);
                root_n[k] = {sq_root_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_n[k]  = r_t[k][33:0];
                root_n[k] = {sq_root_reg[k][30:0], 1'b0};
            end
        end

        // rounded numerator, ties go up
        for (int i = 0; i < 3; i++)
            num[i] = {1'b0, sq_mag_reg[SQ][i], 30'd0}
                     + {31'd0, sq_root_reg[SQ][31:1]};

        for (int k = 0; k < DV; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d_t[k][i] = {d_rem_reg[k][i], d_low_reg[k][i][31]};
                if (d_t[k][i] >= {1'b0, d_len_reg[k]})
                begin
                    d_rem_n[k][i] = 32'(d_t[k][i] - {1'b0, d_len_reg[k]});
                    d_q_n[k][i]   = {d_q_reg[k][i][30:0], 1'b1};
                end
                else
                begin
                    d_rem_n[k][i] = d_t[k][i][31:0];
                    d_q_n[k][i]   = {d_q_reg[k][i][30:0], 1'b0};
                end
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            q_sat[i] = d_q_reg[DV][i][31] ? 32'h7fffffff : d_q_reg[DV][i];
            o_val[i] = d_p_reg[DV].zero ? '0
                     : (d_p_reg[DV].neg[i] ? (~q_sat[i] + 32'd1) : q_sat[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            o_v_reg <= 1'b0;
            for (int k = 0; k <= SQ; k++)
                sq_v_reg[k] <= 1'b0;
            for (int k = 0; k <= DV; k++)
                d_v_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg       <= {v_reg[4:1], in_v};
            sq_v_reg[0] <= v_reg[4];
            for (int k = 1; k <= SQ; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            d_v_reg[0] <= sq_v_reg[SQ];
            for (int k = 1; k <= DV; k++)
                d_v_reg[k] <= d_v_reg[k-1];
            o_v_reg <= d_v_reg[DV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // sign and magnitude
            p_reg[1].tag  <= in.tag;
            p_reg[1].neg  <= neg_n;
            p_reg[1].zero <= 1'b0;
            mag1_reg      <= mag_n;
            // leading one and shift toward bit 30
            p_reg[2].tag  <= p_reg[1].tag;
            p_reg[2].neg  <= p_reg[1].neg;
            p_reg[2].zero <= m_or == '0;
            mag2_reg      <= mag1_reg;
            right2_reg    <= msb > 6'd30;
            sh2_reg       <= (msb > 6'd30) ? (msb - 6'd30) : (6'd30 - msb);
            // shifted magnitudes
            p_reg[3]      <= p_reg[2];
            mag3_reg      <= shifted;
            // squares
            p_reg[4]      <= p_reg[3];
            mag4_reg      <= mag3_reg;
            for (int i = 0; i < 3; i++)
                sq4_reg[i] <= mag3_reg[i] * mag3_reg[i];
            // sum of squares into the root pipeline
            sq_p_reg[0]    <= p_reg[4];
            sq_mag_reg[0]  <= mag4_reg;
            sq_n_reg[0]    <= 64'(sq4_reg[0]) + 64'(sq4_reg[1]) + 64'(sq4_reg[2]);
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 1; k <= SQ; k++)
            begin
                sq_p_reg[k]    <= sq_p_reg[k-1];
                sq_mag_reg[k]  <= sq_mag_reg[k-1];
                sq_n_reg[k]    <= {sq_n_reg[k-1][61:0], 2'b00};
                sq_rem_reg[k]  <= rem_n[k-1];
                sq_root_reg[k] <= root_n[k-1];
            end
            // divide setup
            d_p_reg[0]   <= sq_p_reg[SQ];
            d_len_reg[0] <= sq_root_reg[SQ];
            for (int i = 0; i < 3; i++)
            begin
                d_rem_reg[0][i] <= {2'b00, num[i][61:32]};
                d_low_reg[0][i] <= num[i][31:0];
                d_q_reg[0][i]   <= '0;
            end
            for (int k = 1; k <= DV; k++)
            begin
                d_p_reg[k]   <= d_p_reg[k-1];
                d_len_reg[k] <= d_len_reg[k-1];
                d_rem_reg[k] <= d_rem_n[k-1];
                d_q_reg[k]   <= d_q_n[k-1];
                for (int i = 0; i < 3; i++)
                    d_low_reg[k][i] <= {d_low_reg[k-1][i][30:0], 1'b0};
            end
            // output register
            o_reg.atom_out    <= d_p_reg[DV].tag.atom;
            o_reg.phase_out   <= d_p_reg[DV].tag.phase;
            o_reg.new_spin_x  <= o_val[0];
            o_reg.new_spin_y  <= o_val[1];
            o_reg.new_spin_z  <= o_val[2];
            o_reg.zero_length <= d_p_reg[DV].zero;
        end
    end

    assign out_v = o_v_reg;
    assign out   = o_reg;

endmodule

@@ rtl/core/llg_heun_spin_integrator.sv @@
`timescale 1ns / 1ps
// throughput: one transaction per cycle while result_stall does not hold the back end,
// set by the fully pipelined slope, step and norm units
// the root and divide units resolve one result bit per stage, 32 stages each
// reset: asynchronous active low, clears control state and loads register defaults
// the per-atom start store is not cleared; a corrector needs its predictor first
// ----------------------------------------------------------------------------
// llg_heun_spin_integrator
// heun integrator for the llg equation, one atom per transaction
// ----------------------------------------------------------------------------
`include "llg_heun_spin_integrator_assert.svh"

module llg_heun_spin_integrator #(
    parameter int ATOMS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // item channel
    input  logic                             item_valid,
    output logic                             item_stall,
    input  llgh_pkg::item_t                  item,
    // result channel
    output logic                             result_valid,
    input  logic                             result_stall,
    output llgh_pkg::result_t                result,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [llgh_pkg::CFG_IW-1:0]      cfg_index,
    input  logic [31:0]                      cfg_data
);

    llgh_pkg::cfg_t      cfg_reg;
    llgh_pkg::q_status_t q_stat;
    llgh_pkg::work_t     f_work, q_work;
    llgh_pkg::slope_t    sl_out;
    llgh_pkg::vec_t      up_out;
    logic                f_push;
    logic                pop;
    logic                adv;
    logic                sl_v, up_v;

    // whole back end moves together; the output register is its last stage
    assign adv = !result_valid || !result_stall;
    assign pop = adv && !q_stat.empty;

    // configuration: always ready, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prec_gain <= 16'd32768;
            cfg_reg.damp_gain <= 16'd16384;
            cfg_reg.time_step <= '0;
            cfg_reg.pin_x     <= '0;
            cfg_reg.pin_y     <= '0;
            cfg_reg.pin_z     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                llgh_pkg::REG_PREC_GAIN: cfg_reg.prec_gain <= cfg_data[15:0];
                llgh_pkg::REG_DAMP_GAIN: cfg_reg.damp_gain <= cfg_data[15:0];
                llgh_pkg::REG_TIME_STEP: cfg_reg.time_step <= cfg_data;
                llgh_pkg::REG_PIN_X:     cfg_reg.pin_x     <= cfg_data;
                llgh_pkg::REG_PIN_Y:     cfg_reg.pin_y     <= cfg_data;
                llgh_pkg::REG_PIN_Z:     cfg_reg.pin_z     <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // front: accept, range check, pinning add
    llgh_front #(
        .ATOMS(ATOMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item      (item),
        .cfg       (cfg_reg),
        .q_full    (q_stat.full),
        .push      (f_push),
        .work      (f_work)
    );

    // decoupling queue, front keeps accepting while the back end stalls, until the queue is full
    llgh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (f_push),
        .wr_data(f_work),
        .pop    (pop),
        .rd_data(q_work),
        .status (q_stat)
    );

    // llg slope
    llgh_slope u_slope (
        .clk  (clk),
        .rst_n(rst_n),
        .adv  (adv),
        .in_v (pop),
        .w    (q_work),
        .cfg  (cfg_reg),
        .out_v(sl_v),
        .out  (sl_out)
    );

    // start store and time step
    llgh_update #(
        .ATOMS(ATOMS)
    ) u_update (
        .clk  (clk),
        .rst_n(rst_n),
        .adv  (adv),
        .in_v (sl_v),
        .in   (sl_out),
        .cfg  (cfg_reg),
        .out_v(up_v),
        .out  (up_out)
    );

    // normalization and output register
    llgh_norm u_norm (
        .clk  (clk),
        .rst_n(rst_n),
        .adv  (adv),
        .in_v (up_v),
        .in   (up_out),
        .out_v(result_valid),
        .out  (result)
    );

    `LLGH_ASSERT_IMP(a_queue_state, clk, rst_n, 1'b1, !(q_stat.full && q_stat.empty))
    `LLGH_ASSERT_IMP(a_zero_result, clk, rst_n, result_valid && result.zero_length, result.new_spin_x == '0 && result.new_spin_y == '0 && result.new_spin_z == '0)
    `LLGH_ASSERT_IMP(a_unit_bound, clk, rst_n, result_valid, $signed(result.new_spin_x) <= 32'sd1073741824 && $signed(result.new_spin_x) >= -32'sd1073741824)
    `LLGH_ASSERT_NEXT(a_push_lands, clk, rst_n, f_push && q_stat.empty && !adv, !q_stat.empty)

endmodule

@@ bench/llg_heun_spin_integrator_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llg_heun_spin_integrator_test
// self-checking bench for the heun llg integrator: a bit-exact predictor of
// both phases runs alongside the block, with random idling on both channels,
// a long result hold-off and register sweeps across the extremes
// ----------------------------------------------------------------------------
module llg_heun_spin_integrator_test;

    localparam int NATOMS      = 1024;
    localparam int DRAIN_WAIT  = 120;     // longer than the latency from accepted item to result
    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          item_valid = 1'b0;
    logic                          item_stall;
    llgh_pkg::item_t               item = '0;
    logic                          result_valid;
    logic                          result_stall = 1'b0;
    llgh_pkg::result_t             result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [llgh_pkg::CFG_IW-1:0]   cfg_index = '0;
    logic [31:0]                   cfg_data = '0;

    // shadow of the register file and the per-atom store
    logic [15:0]     g_prec = 16'd32768;
    logic [15:0]     g_damp = 16'd16384;
    logic [31:0]     dt_q32 = '0;
    llgh_pkg::word_t pin_h [3] = '{0, 0, 0};
    llgh_pkg::word_t start_spin [NATOMS][3];
    llgh_pkg::word_t stored_slope [NATOMS][3];
    bit              atom_written [NATOMS];
    int              written_list [$];

    llgh_pkg::result_t spin_expect_q [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;        // no idling on either side
    int          hold_token = 0;      // bump to start a long result hold-off
    int          hold_seen = 0;
    int          hold_left = 0;

    llg_heun_spin_integrator #(.ATOMS(NATOMS)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor arithmetic
    // ------------------------------------------------------------------

    // clamp a wide signed value to a 32-bit word
    function automatic llgh_pkg::word_t clamp_word(input logic signed [79:0] x);
        llgh_pkg::word_t r;
        if (x > 80'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -80'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // one component of a x b in Q-format, floor shift by 30
    function automatic llgh_pkg::word_t cross_term(input llgh_pkg::word_t a1,
                                                   input llgh_pkg::word_t b2,
                                                   input llgh_pkg::word_t a2,
                                                   input llgh_pkg::word_t b1);
        logic signed [79:0] p, q;
        p = a1;
        q = a2;
        p = p * b2;
        q = q * b1;
        return clamp_word((p - q) >>> 30);
    endfunction

    // dS = g1 (S x H) + g2 (S x (S x H))
    function automatic void llg_slope(input llgh_pkg::word_t s[3],
                                      input llgh_pkg::word_t h[3],
                                      output llgh_pkg::word_t d[3]);
        llgh_pkg::word_t c[3], e[3];
        logic signed [79:0] acc, g1, g2;
        c[0] = cross_term(s[1], h[2], s[2], h[1]);
        c[1] = cross_term(s[2], h[0], s[0], h[2]);
        c[2] = cross_term(s[0], h[1], s[1], h[0]);
        e[0] = cross_term(s[1], c[2], s[2], c[1]);
        e[1] = cross_term(s[2], c[0], s[0], c[2]);
        e[2] = cross_term(s[0], c[1], s[1], c[0]);
        g1 = {64'd0, g_prec};
        g2 = {64'd0, g_damp};
        for (int i = 0; i < 3; i++)
        begin
            acc = g1 * c[i] + g2 * e[i];
            d[i] = clamp_word(acc >>> 16);
        end
    endfunction

    // floor(a * dt / 2^sh)
    function automatic longint scale_by_dt(input longint a, input int sh);
        logic signed [95:0] p, t;
        p = a;
        t = {64'd0, dt_q32};
        p = p * t;
        p = p >>> sh;
        return longint'(p);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // normalize to unit length in Q2.30, sets the zero flag on a null vector
    function automatic void unit_vector(input longint v[3], output llgh_pkg::word_t o[3],
                                        output logic zero);
        longint unsigned mag[3], len, q, sum;
        bit neg[3];
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
        end
        zero = (mag[0] | mag[1] | mag[2]) == 0;
        o = '{0, 0, 0};
        if (!zero)
        begin
            while ((mag[0] | mag[1] | mag[2]) >= 64'h80000000)
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            while ((mag[0] | mag[1] | mag[2]) < 64'h40000000)
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = ((mag[i] << 30) + (len >> 1)) / len;
                if (q > 64'h7fffffff)
                    q = 64'h7fffffff;
                o[i] = neg[i] ? -llgh_pkg::word_t'(q) : llgh_pkg::word_t'(q);
            end
        end
    endfunction

    // one heun step for an accepted transaction, updates the per-atom store
    function automatic llgh_pkg::result_t integrate_spin(input llgh_pkg::item_t it);
        llgh_pkg::result_t r;
        llgh_pkg::word_t s[3], h[3], d[3], o[3];
        longint v[3];
        logic zero;
        int a;
        a = it.atom_index;
        s = '{it.spin_x, it.spin_y, it.spin_z};
        h = '{it.field_x, it.field_y, it.field_z};
        if (it.func == llgh_pkg::PHASE_PREDICT)
        begin
            llg_slope(s, h, d);
            start_spin[a] = s;
            stored_slope[a] = d;
            for (int i = 0; i < 3; i++)
                v[i] = longint'(s[i]) + scale_by_dt(longint'(d[i]), 26);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                h[i] = clamp_word(80'(h[i]) + 80'(pin_h[i]));
            llg_slope(s, h, d);
            for (int i = 0; i < 3; i++)
                v[i] = longint'(start_spin[a][i])
                     + scale_by_dt(longint'(stored_slope[a][i]) + longint'(d[i]), 27);
        end
        unit_vector(v, o, zero);
        r.atom_out = it.atom_index;
        r.phase_out = it.func;
        r.new_spin_x = o[0];
        r.new_spin_y = o[1];
        r.new_spin_z = o[2];
        r.zero_length = zero;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // offer one transaction, optionally after a one-cycle gap, and predict it
    task automatic send_item(input llgh_pkg::item_t it);
        if (!quiet && $urandom_range(99) < 47)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        spin_expect_q.push_back(integrate_spin(it));
        items_sent++;
        if (it.func == llgh_pkg::PHASE_PREDICT && !atom_written[it.atom_index])
        begin
            atom_written[it.atom_index] = 1'b1;
            written_list.push_back(it.atom_index);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (spin_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [llgh_pkg::CFG_IW-1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            llgh_pkg::REG_PREC_GAIN: g_prec = val[15:0];
            llgh_pkg::REG_DAMP_GAIN: g_damp = val[15:0];
            llgh_pkg::REG_TIME_STEP: dt_q32 = val;
            llgh_pkg::REG_PIN_X:     pin_h[0] = val;
            llgh_pkg::REG_PIN_Y:     pin_h[1] = val;
            llgh_pkg::REG_PIN_Z:     pin_h[2] = val;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [15:0] g1, input logic [15:0] g2,
                               input logic [31:0] dt, input llgh_pkg::word_t px,
                               input llgh_pkg::word_t py, input llgh_pkg::word_t pz);
        wait_drained();
        write_reg(llgh_pkg::REG_PREC_GAIN, {16'd0, g1});
        write_reg(llgh_pkg::REG_DAMP_GAIN, {16'd0, g2});
        write_reg(llgh_pkg::REG_TIME_STEP, dt);
        write_reg(llgh_pkg::REG_PIN_X, px);
        write_reg(llgh_pkg::REG_PIN_Y, py);
        write_reg(llgh_pkg::REG_PIN_Z, pz);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic llgh_pkg::word_t rand_word();
        return llgh_pkg::word_t'($urandom);
    endfunction

    // spin-like component within [-1, 1) in Q2.30
    function automatic llgh_pkg::word_t rand_spin();
        return llgh_pkg::word_t'(int'($urandom_range(32'h7fffffff, 0)) - 32'sh40000000);
    endfunction

    // field of moderate size, a few tesla in Q8.24
    function automatic llgh_pkg::word_t rand_field();
        return llgh_pkg::word_t'(int'($urandom_range(32'h0fffffff, 0)) - 32'sh08000000);
    endfunction

    function automatic llgh_pkg::item_t make_item(input logic ph, input int a, input bit wild);
        llgh_pkg::item_t it;
        it.func = ph;
        it.atom_index = a[9:0];
        it.spin_x = wild ? rand_word() : rand_spin();
        it.spin_y = wild ? rand_word() : rand_spin();
        it.spin_z = wild ? rand_word() : rand_spin();
        it.field_x = wild ? rand_word() : rand_field();
        it.field_y = wild ? rand_word() : rand_field();
        it.field_z = wild ? rand_word() : rand_field();
        return it;
    endfunction

    function automatic llgh_pkg::item_t vec_item(input logic ph, input int a,
                                                 input llgh_pkg::word_t sx,
                                                 input llgh_pkg::word_t sy,
                                                 input llgh_pkg::word_t sz,
                                                 input llgh_pkg::word_t hx,
                                                 input llgh_pkg::word_t hy,
                                                 input llgh_pkg::word_t hz);
        llgh_pkg::item_t it;
        it.func = ph;
        it.atom_index = a[9:0];
        it.spin_x = sx;
        it.spin_y = sy;
        it.spin_z = sz;
        it.field_x = hx;
        it.field_y = hy;
        it.field_z = hz;
        return it;
    endfunction

    // predictors and correctors on random atoms with random content, some noise
    task automatic send_mixed(input int n);
        int a, r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 45 || written_list.size() == 0)
                send_item(make_item(llgh_pkg::PHASE_PREDICT, $urandom_range(NATOMS - 1),
                                    r >= 40));
            else
            begin
                // corrector only reads atoms that a predictor has filled
                a = written_list[$urandom_range(written_list.size() - 1)];
                send_item(make_item(llgh_pkg::PHASE_CORRECT, a, r >= 90));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: stall generation and checking
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_token != hold_seen)
        begin
            hold_seen <= hold_token;
            hold_left <= 400;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 32);
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0d] atom %0d %s: got %h expected %h", cycles, result.atom_out,
                 what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        llgh_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (spin_expect_q.size() == 0)
                report_mismatch("unexpected result transaction", 0, 0);
            else
            begin
                want = spin_expect_q.pop_front();
                if (result.atom_out !== want.atom_out)
                    report_mismatch("atom_out", result.atom_out, want.atom_out);
                if (result.phase_out !== want.phase_out)
                    report_mismatch("phase_out", result.phase_out, want.phase_out);
                if (result.new_spin_x !== want.new_spin_x)
                    report_mismatch("new_spin_x", result.new_spin_x, want.new_spin_x);
                if (result.new_spin_y !== want.new_spin_y)
                    report_mismatch("new_spin_y", result.new_spin_y, want.new_spin_y);
                if (result.new_spin_z !== want.new_spin_z)
                    report_mismatch("new_spin_z", result.new_spin_z, want.new_spin_z);
                if (result.zero_length !== want.zero_length)
                    report_mismatch("zero_length", result.zero_length, want.zero_length);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     spin_expect_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset register values, dt zero so each result is just the normalized start spin
    task automatic test_reset_defaults();
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 0, 0, 0, 0, 32'sh01000000, 0, 0));
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 1, 32'sh40000000, 0, 0,
                           0, 32'sh01000000, 0));
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 2,
                           32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                           32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 3,
                           32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 1023, 32'sh80000000, 32'sh7fffffff, 1,
                           32'sh7fffffff, 32'sh80000000, 0));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 1023, 0, 32'sh40000000, 0,
                           0, 0, 32'sh7fffffff));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 0, 0, 0, 0, 0, 0, 0));
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 4, 1, 0, 0, 0, 0, 0));
    endtask

    // large step, strong gains and pinning: saturation and corrector sums
    task automatic test_directed_extremes();
        load_config(16'hffff, 16'h8000, 32'hffffffff, 32'sh7fffffff, 32'sh80000000,
                    32'sh7fffffff);
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 10, 32'sh40000000, 0, 0,
                           0, 32'sh7fffffff, 0));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 10, 32'sh40000000, 0, 0,
                           32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 11,
                           32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                           32'sh80000000, 32'sh7fffffff, 32'sh80000000));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 11,
                           32'sh80000000, 32'sh80000000, 32'sh80000000,
                           32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 12, 0, 0, 0, 32'sh7fffffff, 0, 0));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 12, 0, 0, 0, 32'sh7fffffff, 0, 0));
        // zero gains: the slope vanishes and only the stored spin survives
        load_config(16'd0, 16'd0, 32'h80000000, 32'sh80000000, 32'sh7fffffff,
                    32'sh80000000);
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 13, 32'sh20000000, 32'sh20000000, 0,
                           32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 13, 32'sh7fffffff, 0, 0,
                           32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 12, 1, 1, 1, 0, 0, 0));
        // damping gain above its nominal range is used as given
        load_config(16'h4000, 16'hffff, 32'h10000000, 0, 0, 0);
        send_item(vec_item(llgh_pkg::PHASE_PREDICT, 14,
                           32'sh40000000, 32'sh10000000, 32'sh08000000,
                           0, 32'sh04000000, 32'sh02000000));
        send_item(vec_item(llgh_pkg::PHASE_CORRECT, 14,
                           32'sh3f000000, 32'sh11000000, 32'sh09000000,
                           0, 32'sh04000000, 32'sh02000000));
    endtask

    // random traffic across several register settings
    task automatic test_config_sweep();
        load_config(16'd32768, 16'd16384, 32'h00100000, 0, 0, 0);
        send_mixed(120);
        load_config(16'd0, 16'd32768, 32'h01000000, rand_field(), rand_field(), rand_field());
        send_mixed(120);
        load_config(16'd65535, 16'd0, 32'hffffffff, rand_word(), rand_word(), rand_word());
        send_mixed(120);
        load_config(16'($urandom_range(65535)), 16'($urandom_range(32768)), $urandom,
                    rand_field(), rand_field(), rand_field());
        send_mixed(120);
    endtask

    // results held off while items keep coming, then a back-to-back stretch
    task automatic test_backpressure();
        load_config(16'd60000, 16'd12000, 32'h00400000, rand_field(), rand_field(),
                    rand_field());
        hold_token = hold_token + 1;
        send_mixed(200);
        wait_drained();
        quiet = 1'b1;
        send_mixed(150);
        quiet = 1'b0;
        // sender pauses until everything is back
        wait_drained();
    endtask

    task automatic test_random();
        load_config(16'($urandom_range(65535)), 16'($urandom_range(32768)),
                    $urandom_range(32'h03ffffff),
                    rand_field(), rand_field(), rand_field());
        send_mixed(300);
        load_config(16'($urandom_range(65535)), 16'($urandom_range(65535)), $urandom,
                    rand_word(), rand_word(), rand_word());
        send_mixed(300);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_extremes();
        test_config_sweep();
        test_backpressure();
        test_random();
        wait_drained();
        $display("sent %0d transactions, checked %0d results over %0d atoms",
                 items_sent, results_seen, written_list.size());
        $display("covered both phases, gain and step extremes, pinning saturation, long hold-off");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
